### rtl/core/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, constants and roll helpers of the Poisson bootstrap accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    localparam int ROW_COUNT = 64;
    localparam int ROW_W    = 6;
    localparam int CDF_LEN  = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_SEED = 1'b1;

    localparam logic       ACTION_ADD   = 1'b0;
    localparam logic       ACTION_FLUSH = 1'b1;

    localparam logic [31:0] LCG_MUL_LO = 32'h4C957F2D;
    localparam logic [31:0] LCG_MUL_HI = 32'h5851F42D;
    localparam logic [63:0] LCG_ADD    = 64'd1442695040888963407;
    localparam logic [31:0] LOW_MASK   = 32'h00FFFFFF;

    localparam logic [31:0] CDF [CDF_LEN] = '{
        32'd1580030169, 32'd3160060337, 32'd3950075422, 32'd4213413783,
        32'd4279248373, 32'd4292415291, 32'd4294609777, 32'd4294923275,
        32'd4294962462, 32'd4294966816, 32'd4294967251, 32'd4294967291,
        32'd4294967295
    };

    typedef struct packed {
        logic load_item;
        logic ram_rd;
        logic ram_wr;
        logic take_byte;
        logic lcg_start;
        logic fill;
        logic w_byte;
        logic w_coin;
        logic w_full;
        logic next_row;
        logic save_shared;
        logic clear_all;
    } ctrl_cmd_t;

    typedef struct packed {
        logic byte_mode;
        logic left_zero;
        logic byte_decided;
        logic lcg_done;
        logic last_row;
        logic count_zero;
    } dp_status_t;

    function automatic logic [3:0] walk_from(logic [3:0] k, logic [31:0] coin);
        logic [3:0] r;
        r = 4'(CDF_LEN - 1);
        for (int j = CDF_LEN - 1; j >= 0; j--)
        begin
            if (4'(j) >= k && CDF[j] >= coin)
            begin
                r = 4'(j);
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] first_above(logic [31:0] lo);
        logic [3:0] r;
        r = 4'(CDF_LEN - 1);
        for (int j = CDF_LEN - 1; j >= 0; j--)
        begin
            if (CDF[j] > lo)
            begin
                r = 4'(j);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pba_if.sv
// ----------------------------------------------------------------------------
// pba_if
// Item, result and register write channels of the bootstrap accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] value;
    logic [63:0] seed;
    modport source (output valid, action, value, seed, input ready);
    modport sink   (input valid, action, value, seed, output ready);
endinterface

interface pba_result_if;
    logic        valid;
    logic        ready;
    logic [5:0]  row;
    logic [63:0] sum;
    logic [31:0] item_count;
    logic        last;
    modport source (output valid, row, sum, item_count, last, input ready);
    modport sink   (input valid, row, sum, item_count, last, output ready);
endinterface

interface pba_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer: walks rows for an add, draws rolls, and runs the flush.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire logic                   item_action,
    output logic                        item_ready,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    input  wire pba_pkg::dp_status_t    status,
    output pba_pkg::ctrl_cmd_t          cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_READ      = 11'b000_0000_0010,
        S_WRITE     = 11'b000_0000_0100,
        S_ROLL      = 11'b000_0000_1000,
        S_DRAW_FILL = 11'b000_0001_0000,
        S_EVAL      = 11'b000_0010_0000,
        S_DRAW_COIN = 11'b000_0100_0000,
        S_DRAW_FULL = 11'b000_1000_0000,
        S_NEXT      = 11'b001_0000_0000,
        S_FLUSH_RD  = 11'b010_0000_0000,
        S_FLUSH_OUT = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (item_action == pba_pkg::ACTION_ADD)
                    begin
                        state_next = S_READ;
                    end
                    else if (!status.count_zero)
                    begin
                        state_next = S_FLUSH_RD;
                    end
                end
            end
            S_READ:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.ram_wr = 1'b1;
                state_next = S_ROLL;
            end
            S_ROLL:
            begin
                if (status.byte_mode)
                begin
                    if (status.left_zero)
                    begin
                        cmd.lcg_start = 1'b1;
                        state_next    = S_DRAW_FILL;
                    end
                    else
                    begin
                        cmd.take_byte = 1'b1;
                        state_next    = S_EVAL;
                    end
                end
                else
                begin
                    cmd.lcg_start = 1'b1;
                    state_next    = S_DRAW_FULL;
                end
            end
            S_DRAW_FILL:
            begin
                if (status.lcg_done)
                begin
                    cmd.fill   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.byte_decided)
                begin
                    cmd.w_byte = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.lcg_start = 1'b1;
                    state_next    = S_DRAW_COIN;
                end
            end
            S_DRAW_COIN:
            begin
                if (status.lcg_done)
                begin
                    cmd.w_coin = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_DRAW_FULL:
            begin
                if (status.lcg_done)
                begin
                    cmd.w_full = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (status.last_row)
                begin
                    cmd.save_shared = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.next_row = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_FLUSH_RD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_FLUSH_OUT;
            end
            S_FLUSH_OUT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    if (status.last_row)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_row = 1'b1;
                        state_next   = S_FLUSH_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/pba_dp.sv
// ----------------------------------------------------------------------------
// pba_dp
// Datapath: row sums, item count, generator state and roll decode.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pba_pkg::ctrl_cmd_t                 cmd,
    output pba_pkg::dp_status_t                     status,
    input  wire logic                               item_action,
    input  wire logic [63:0]                        item_value,
    input  wire logic [63:0]                        item_seed,
    input  wire logic                               cfg_write,
    input  wire logic [pba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [63:0]                        cfg_data,
    output logic [5:0]                              res_row,
    output logic [63:0]                             res_sum,
    output logic [31:0]                             res_count,
    output logic                                    res_last
);

    logic                       fast_reg;
    logic [63:0]                shared_lcg_reg;
    logic [31:0]                shared_buf_reg;
    logic [1:0]                 shared_left_reg;
    logic [31:0]                count_reg;
    logic [63:0]                value_reg;
    logic                       own_seed_reg;
    logic [pba_pkg::ROW_W-1:0]  row_reg;
    logic [3:0]                 w_reg;
    logic [63:0]                lcg_reg;
    logic [31:0]                buf_reg;
    logic [1:0]                 left_reg;
    logic                       busy_reg;
    logic [1:0]                 phase_reg;
    logic                       done_reg;
    logic [63:0]                acc_reg;
    logic [31:0]                hi_acc_reg;
    logic [pba_pkg::ROW_COUNT-1:0] vld_reg;
    logic                       vld_q_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] rd_data;
    logic [63:0] old_sum;
    logic [63:0] weighted;
    logic [63:0] new_sum;
    logic [7:0]  cur_byte;
    logic [31:0] lo_word;
    logic [3:0]  k_byte;
    logic [31:0] draw;

    pba_ram #(
        .WIDTH (64),
        .DEPTH (pba_pkg::ROW_COUNT)
    ) u_sums (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (row_reg),
        .wr_data (new_sum),
        .rd_en   (cmd.ram_rd),
        .rd_addr (row_reg),
        .rd_data (rd_data)
    );

    assign mul_a    = (phase_reg == 2'd2) ? lcg_reg[63:32] : lcg_reg[31:0];
    assign mul_b    = (phase_reg == 2'd1) ? pba_pkg::LCG_MUL_HI : pba_pkg::LCG_MUL_LO;
    assign prod     = mul_a * mul_b;
    assign draw     = lcg_reg[63:32];
    assign old_sum  = vld_q_reg ? rd_data : 64'd0;
    assign weighted = ({64{w_reg[0]}} & value_reg)
                    + ({64{w_reg[1]}} & {value_reg[62:0], 1'b0})
                    + ({64{w_reg[2]}} & {value_reg[61:0], 2'b00})
                    + ({64{w_reg[3]}} & {value_reg[60:0], 3'b000});
    assign new_sum  = old_sum + weighted;
    assign cur_byte = buf_reg[{left_reg, 3'b000} +: 8];
    assign lo_word  = {cur_byte, 24'd0};
    assign k_byte   = pba_pkg::first_above(lo_word);

    assign status.byte_mode    = fast_reg;
    assign status.left_zero    = (left_reg == 2'd0);
    assign status.byte_decided = (lo_word | pba_pkg::LOW_MASK) < pba_pkg::CDF[k_byte];
    assign status.lcg_done     = done_reg;
    assign status.last_row     = (row_reg == pba_pkg::ROW_W'(pba_pkg::ROW_COUNT - 1));
    assign status.count_zero   = (count_reg == 32'd0);

    assign res_row   = 6'(row_reg);
    assign res_sum   = old_sum;
    assign res_count = count_reg;
    assign res_last  = status.last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg        <= 1'b1;
            shared_lcg_reg  <= 64'd0;
            shared_buf_reg  <= 32'd0;
            shared_left_reg <= 2'd0;
            count_reg       <= 32'd0;
            busy_reg        <= 1'b0;
            phase_reg       <= 2'd0;
            done_reg        <= 1'b0;
            vld_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    pba_pkg::CFG_BYTE_MODE:
                    begin
                        fast_reg <= cfg_data[0];
                    end
                    pba_pkg::CFG_SHARED_SEED:
                    begin
                        shared_lcg_reg  <= cfg_data;
                        shared_left_reg <= 2'd0;
                    end
                    default:
                    begin
                        fast_reg <= fast_reg;
                    end
                endcase
            end
            if (cmd.save_shared && !own_seed_reg)
            begin
                shared_lcg_reg  <= lcg_reg;
                shared_buf_reg  <= buf_reg;
                shared_left_reg <= left_reg;
            end
            if (cmd.load_item && item_action == pba_pkg::ACTION_ADD
                && count_reg != 32'hFFFF_FFFF)
            begin
                count_reg <= count_reg + 32'd1;
            end
            if (cmd.clear_all)
            begin
                count_reg <= 32'd0;
                vld_reg   <= '0;
            end
            if (cmd.ram_wr)
            begin
                vld_reg[row_reg] <= 1'b1;
            end
            if (cmd.lcg_start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            value_reg    <= item_value;
            own_seed_reg <= (item_seed != 64'd0);
            row_reg      <= '0;
            w_reg        <= 4'd1;
            if (item_seed != 64'd0)
            begin
                lcg_reg  <= item_seed;
                buf_reg  <= 32'd0;
                left_reg <= 2'd0;
            end
            else
            begin
                lcg_reg  <= shared_lcg_reg;
                buf_reg  <= shared_buf_reg;
                left_reg <= shared_left_reg;
            end
        end
        if (cmd.ram_rd)
        begin
            vld_q_reg <= vld_reg[row_reg];
        end
        if (cmd.next_row)
        begin
            row_reg <= row_reg + pba_pkg::ROW_W'(1);
        end
        if (cmd.take_byte)
        begin
            left_reg <= left_reg - 2'd1;
        end
        if (cmd.fill)
        begin
            buf_reg  <= draw;
            left_reg <= 2'd3;
        end
        if (cmd.w_byte)
        begin
            w_reg <= k_byte;
        end
        if (cmd.w_coin)
        begin
            w_reg <= pba_pkg::walk_from(k_byte, lo_word | (pba_pkg::LOW_MASK & draw));
        end
        if (cmd.w_full)
        begin
            w_reg <= pba_pkg::walk_from(4'd0, draw);
        end
        if (busy_reg)
        begin
            case (phase_reg)
                2'd0:
                begin
                    acc_reg <= prod;
                end
                2'd1:
                begin
                    hi_acc_reg <= prod[31:0];
                end
                2'd2:
                begin
                    hi_acc_reg <= hi_acc_reg + prod[31:0];
                end
                default:
                begin
                    lcg_reg <= acc_reg + {hi_acc_reg, 32'd0} + pba_pkg::LCG_ADD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/poisson_bootstrap_accumulator.sv
// ----------------------------------------------------------------------------
// poisson_bootstrap_accumulator
// Keeps 64 Poisson(1) bootstrap sums of signed values and reports them on flush.
// ----------------------------------------------------------------------------
// channel  dir  payload                          accepted when
// item     in   action, value, seed              item.valid && item.ready
// result   out  row, sum, item_count, last       result.valid && result.ready
// cfg      in   index, data                      cfg.valid && cfg.ready
//
// Per row an add runs S_READ, S_WRITE, S_ROLL, then S_EVAL on a buffer byte in
// byte mode (S_DRAW_FILL first if empty, S_DRAW_COIN if undecided) or else
// S_DRAW_FULL, then S_NEXT; draws run four phases on one shared 32x32 multiplier.
// A flush reads each row and holds it in S_FLUSH_OUT until result.ready.
// Reset clears all sums, the count and the shared generator state at once.
// item.ready is low while an item is in work; cfg.ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module poisson_bootstrap_accumulator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pba_item_if.sink      item,
    pba_result_if.source  result,
    pba_cfg_if.sink       cfg
);

    pba_pkg::ctrl_cmd_t  cmd;
    pba_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    pba_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_action  (item.action),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    pba_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .item_action (item.action),
        .item_value  (item.value),
        .item_seed   (item.seed),
        .cfg_write   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .res_row     (result.row),
        .res_sum     (result.sum),
        .res_count   (result.item_count),
        .res_last    (result.last)
    );

    a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !item.ready)
        else $error("item taken during flush");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.last |=> item.ready && !result.valid)
        else $error("not idle after final result");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.item_count != 32'd0)
        else $error("flush reported with zero count");

endmodule

`default_nettype wire

### test/pba_checker.sv
// ----------------------------------------------------------------------------
// pba_checker
// Tracks item and register traffic, predicts every flush report of the
// bootstrap accumulator and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    pba_item_if       item,
    pba_result_if     result,
    pba_cfg_if        cfg,
    output int        errors,
    output int        pending,
    output int        reports_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]  row;
        logic [63:0] sum;
        logic [31:0] item_count;
        logic        last;
    } row_report_t;

    row_report_t reports_due[$];

    logic        fast_mode;
    logic [63:0] shared_gen;
    logic [31:0] shared_bytes;
    logic [1:0]  shared_left;
    logic [63:0] row_sum[pba_pkg::ROW_COUNT];
    logic [31:0] add_count;

    logic [63:0] gen;
    logic [31:0] bytes_buf;
    logic [1:0]  bytes_rem;

    function automatic logic [31:0] next_draw();
        gen = 64'd6364136223846793005 * gen + pba_pkg::LCG_ADD;
        return gen[63:32];
    endfunction

    function automatic logic [3:0] cdf_search(logic [3:0] k, logic [31:0] coin);
        while (k < pba_pkg::CDF_LEN - 1 && pba_pkg::CDF[k] < coin)
            k++;
        return k;
    endfunction

    function automatic logic [3:0] poisson_weight();
        logic [7:0]  b;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [3:0]  k;
        if (!fast_mode)
            return cdf_search(0, next_draw());
        if (bytes_rem == 0)
        begin
            bytes_buf = next_draw();
            bytes_rem = 3;
        end
        else
        begin
            bytes_rem = bytes_rem - 1;
        end
        b = bytes_buf[bytes_rem*8 +: 8];
        lo = {b, 24'd0};
        hi = lo | pba_pkg::LOW_MASK;
        k = cdf_search(0, lo);
        if (pba_pkg::CDF[k] == lo)
            k++;
        if (hi < pba_pkg::CDF[k])
            return k;
        return cdf_search(k, lo | (pba_pkg::LOW_MASK & next_draw()));
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic accept_item(logic act, logic [63:0] val, logic [63:0] sd);
        logic [63:0] w;
        row_report_t rp;
        if (act == pba_pkg::ACTION_FLUSH)
        begin
            if (add_count == 0)
                return;
            for (int r = 0; r < pba_pkg::ROW_COUNT; r++)
            begin
                rp.row = 6'(r);
                rp.sum = row_sum[r];
                rp.item_count = add_count;
                rp.last = (r == pba_pkg::ROW_COUNT - 1);
                reports_due.insert(reports_due.size(), rp);
                row_sum[r] = 0;
            end
            add_count = 0;
            return;
        end
        if (add_count != 32'hFFFF_FFFF)
            add_count++;
        if (sd != 0)
        begin
            gen = sd;
            bytes_buf = 0;
            bytes_rem = 0;
        end
        else
        begin
            gen = shared_gen;
            bytes_buf = shared_bytes;
            bytes_rem = shared_left;
        end
        w = 1;
        for (int r = 0; r < pba_pkg::ROW_COUNT; r++)
        begin
            row_sum[r] = row_sum[r] + w * val;
            w = 64'(poisson_weight());
        end
        if (sd == 0)
        begin
            shared_gen = gen;
            shared_bytes = bytes_buf;
            shared_left = bytes_rem;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_report_t want;
        if (!rst_n)
        begin
            fast_mode = 1'b1;
            shared_gen = 0;
            shared_bytes = 0;
            shared_left = 0;
            add_count = 0;
            for (int r = 0; r < pba_pkg::ROW_COUNT; r++)
                row_sum[r] = 0;
            reports_due.delete();
            errors = 0;
            reports_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == pba_pkg::CFG_BYTE_MODE)
                    fast_mode = cfg.data[0];
                else if (cfg.index == pba_pkg::CFG_SHARED_SEED)
                begin
                    shared_gen = cfg.data;
                    shared_left = 0;
                end
            end
            if (result.valid && result.ready)
            begin
                reports_seen++;
                if (reports_due.size() == 0)
                begin
                    report("unexpected row", 64'(result.row), 0);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (result.row !== want.row)
                        report("row", 64'(result.row), 64'(want.row));
                    if (result.sum !== want.sum)
                        report("sum", result.sum, want.sum);
                    if (result.item_count !== want.item_count)
                        report("item_count", 64'(result.item_count),
                               64'(want.item_count));
                    if (result.last !== want.last)
                        report("last", 64'(result.last), 64'(want.last));
                end
            end
            if (item.valid && item.ready)
                accept_item(item.action, item.value, item.seed);
            pending = reports_due.size();
        end
    end

endmodule

`default_nettype wire

### test/poisson_bootstrap_accumulator_tb.sv
// ----------------------------------------------------------------------------
// poisson_bootstrap_accumulator_tb
// Drives directed and random add and flush items with register changes in
// between, under sender and receiver stalls; the checker predicts every row.
// ----------------------------------------------------------------------------
`default_nettype none

module poisson_bootstrap_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   reports_seen;
    int   send_idle;
    int   recv_idle;
    int   quiet_cycles;
    int   adds_sent;
    int   flushes_sent;

    pba_item_if   item();
    pba_result_if result();
    pba_cfg_if    cfg();

    poisson_bootstrap_accumulator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    pba_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .cfg          (cfg),
        .errors       (errors),
        .pending      (pending),
        .reports_seen (reports_seen)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [63:0] val, logic [63:0] sd);
        item.valid  <= 1'b1;
        item.action <= act;
        item.value  <= val;
        item.seed   <= sd;
        do @(posedge clk); while (!item.ready);
        @(negedge clk);
        if (act == pba_pkg::ACTION_FLUSH)
            flushes_sent++;
        else
            adds_sent++;
        while ($urandom_range(99) < send_idle)
        begin
            item.valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);
    endtask

    task automatic write_reg(logic [pba_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(9))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'(signed'(32'($urandom_range(200)) - 32'd100));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_run(int count);
        logic [63:0] sd;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(11) == 0)
                send_item(pba_pkg::ACTION_FLUSH, {$urandom, $urandom},
                          {$urandom, $urandom});
            else
            begin
                sd = ($urandom_range(9) < 4) ? 64'd0 : {$urandom, $urandom};
                send_item(pba_pkg::ACTION_ADD, pick_value(), sd);
            end
        end
        send_item(pba_pkg::ACTION_FLUSH, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.action = pba_pkg::ACTION_ADD;
        item.value = 0;
        item.seed = 0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = pba_pkg::CFG_BYTE_MODE;
        cfg.data = 0;
        send_idle = 0;
        recv_idle = 0;
        quiet_cycles = 0;
        adds_sent = 0;
        flushes_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(pba_pkg::ACTION_FLUSH, 0, 0);
        send_item(pba_pkg::ACTION_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
        send_item(pba_pkg::ACTION_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pba_pkg::ACTION_ADD, 64'h8000_0000_0000_0000, 64'd0);
        send_item(pba_pkg::ACTION_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_item(pba_pkg::ACTION_ADD, 64'd0, 64'h8000_0000_0000_0000);
        send_item(pba_pkg::ACTION_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pba_pkg::ACTION_FLUSH, 0, 0);
        drain();
        write_reg(pba_pkg::CFG_BYTE_MODE, 64'd0);
        write_reg(pba_pkg::CFG_SHARED_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pba_pkg::ACTION_ADD, 64'd5, 64'd0);
        send_item(pba_pkg::ACTION_ADD, 64'h8000_0000_0000_0000, 64'd0);
        send_item(pba_pkg::ACTION_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd7);
        send_item(pba_pkg::ACTION_FLUSH, 0, 0);
        drain();
        write_reg(pba_pkg::CFG_BYTE_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(pba_pkg::CFG_SHARED_SEED, 64'd0);
        send_item(pba_pkg::ACTION_ADD, 64'd1, 64'd0);
        send_item(pba_pkg::ACTION_ADD, 64'd1, 64'd0);
        send_item(pba_pkg::ACTION_FLUSH, 0, 0);
        drain();

        send_idle = 15;
        recv_idle = 61;
        write_reg(pba_pkg::CFG_SHARED_SEED, {$urandom, $urandom});
        random_run(170);
        drain();
        send_idle = 61;
        recv_idle = 15;
        write_reg(pba_pkg::CFG_BYTE_MODE, 64'd0);
        write_reg(pba_pkg::CFG_SHARED_SEED, {$urandom, $urandom});
        random_run(160);
        drain();
        send_idle = 0;
        recv_idle = 0;
        write_reg(pba_pkg::CFG_BYTE_MODE, 64'd1);
        write_reg(pba_pkg::CFG_SHARED_SEED, 64'h8000_0000_0000_0000);
        random_run(170);
        drain();

        $display("run covered %0d adds and %0d flushes, %0d rows checked",
                 adds_sent, flushes_sent, reports_seen);
        $display("both roll modes, shared and per-item seeds, three stall mixes");
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
